FILE: rtl/kbtb_pkg.sv
// ----------------------------------------------------------------------------
// kbtb_pkg: shared types and constants for the keyed branch target buffer
// Geometry, field widths, entry layout, outcome codes and register indexes.
// ----------------------------------------------------------------------------
package kbtb_pkg;

    // Geometry: sets and ways are powers of two
    localparam int SET_BITS  = 6;
    localparam int SETS      = 2 ** SET_BITS;
    localparam int WAY_BITS  = 2;
    localparam int WAYS      = 2 ** WAY_BITS;
    localparam int ADDR_BITS = 48;
    localparam int AGE_BITS  = 16;

    localparam int CIPHER_W  = 64;
    localparam int TAG_W     = CIPHER_W - SET_BITS;
    localparam int TGT_W     = 64;
    localparam int IKEY_W    = 16;
    localparam int LFSR_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    localparam logic [AGE_BITS-1:0] AGE_MAX   = '1;
    localparam logic [LFSR_W-1:0]   LFSR_SEED = LFSR_W'(1);

    // Result codes
    localparam logic [1:0] OUTCOME_MISS       = 2'd0;
    localparam logic [1:0] OUTCOME_MISPREDICT = 2'd1;
    localparam logic [1:0] OUTCOME_CORRECT    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_D0_INDEX_KEY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_D0_INDEX_HASH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_D0_CONTENT_KEY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_D1_INDEX_KEY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_D1_INDEX_HASH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_D1_CONTENT_KEY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_MODE      = 3'd6;

    // One way of one set, as held in the way RAM
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [TGT_W-1:0]    target;
        logic [AGE_BITS-1:0] age;
    } entry_t;

    typedef logic [SET_BITS-1:0] set_idx_t;
    typedef logic [WAY_BITS-1:0] way_idx_t;

    // Key set of one security domain
    typedef struct packed {
        logic [IKEY_W-1:0]   index_key;
        logic [CIPHER_W-1:0] index_hash;
        logic [TGT_W-1:0]    content_key;
    } domain_keys_t;

    // Status of one lookup
    typedef struct packed {
        logic [1:0] outcome;
        logic       lfsr_step;
    } set_result_t;

endpackage

FILE: rtl/kbtb_way_ram.sv
// ----------------------------------------------------------------------------
// kbtb_way_ram: storage for one way of every set
// One write port and one registered read port, SETS entries of entry_t.
// ----------------------------------------------------------------------------
module kbtb_way_ram
    import kbtb_pkg::*;
(
    input  logic     clk,
    input  logic     rd_en,
    input  set_idx_t rd_addr,
    output entry_t   rd_data,
    input  logic     wr_en,
    input  set_idx_t wr_addr,
    input  entry_t   wr_data
);

    entry_t mem_reg [SETS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/kbtb_index.sv
// ----------------------------------------------------------------------------
// kbtb_index: keyed index and content scrambling
// Select the domain keys, form the cipher word, split it into set and tag,
// and scramble the target with the content key.
// ----------------------------------------------------------------------------
module kbtb_index
    import kbtb_pkg::*;
(
    input  logic [ADDR_BITS-1:0] branch_pc,
    input  logic [ADDR_BITS-1:0] branch_target,
    input  logic                 domain_id,
    input  domain_keys_t         keys0,
    input  domain_keys_t         keys1,
    output set_idx_t             set_idx,
    output logic [TAG_W-1:0]     tag,
    output logic [TGT_W-1:0]     stored_target
);

    domain_keys_t        keys;
    logic [CIPHER_W-1:0] cipher;

    always_comb
    begin
        keys   = domain_id ? keys1 : keys0;
        // the key fills the bits above the branch PC, so none of its bits are lost
        cipher = ((CIPHER_W'(keys.index_key) << ADDR_BITS) | CIPHER_W'(branch_pc))
                 ^ keys.index_hash;
    end

    assign set_idx       = cipher[SET_BITS-1:0];
    assign tag           = cipher[CIPHER_W-1:SET_BITS];
    assign stored_target = TGT_W'(branch_target) ^ keys.content_key;

endmodule

FILE: rtl/kbtb_set_update.sv
// ----------------------------------------------------------------------------
// kbtb_set_update: lookup and update of one set
// Age the valid ways, match the tag, pick a fill victim on a miss, and build
// the new contents of every way of the set.
// ----------------------------------------------------------------------------
module kbtb_set_update
    import kbtb_pkg::*;
(
    input  entry_t [WAYS-1:0] ways,
    input  logic   [WAYS-1:0] valid,
    input  logic [TAG_W-1:0]  tag,
    input  logic [TGT_W-1:0]  stored_target,
    input  logic              repl_mode,
    input  way_idx_t          random_way,
    output entry_t [WAYS-1:0] new_ways,
    output logic   [WAYS-1:0] new_valid,
    output set_result_t       result
);

    logic [AGE_BITS-1:0] aged [WAYS];
    logic                hit_found;
    way_idx_t            hit_way;
    logic                free_found;
    way_idx_t            free_way;
    way_idx_t            old_way;
    logic [AGE_BITS-1:0] old_age;
    way_idx_t            victim;

    always_comb
    begin
        // age every valid way, saturating
        for (int w = 0; w < WAYS; w++)
        begin
            aged[w] = ways[w].age;
            if (valid[w] && (ways[w].age != AGE_MAX))
            begin
                aged[w] = ways[w].age + AGE_BITS'(1);
            end
        end

        // lowest matching way wins
        hit_found = 1'b0;
        hit_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_found && valid[w] && (ways[w].tag == tag))
            begin
                hit_found = 1'b1;
                hit_way   = WAY_BITS'(w);
            end
        end

        // lowest invalid way
        free_found = 1'b0;
        free_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!free_found && !valid[w])
            begin
                free_found = 1'b1;
                free_way   = WAY_BITS'(w);
            end
        end

        // oldest way after aging, lowest index on a tie
        old_way = '0;
        old_age = aged[0];
        for (int w = 1; w < WAYS; w++)
        begin
            if (aged[w] > old_age)
            begin
                old_way = WAY_BITS'(w);
                old_age = aged[w];
            end
        end

        if (hit_found)
        begin
            victim = hit_way;
        end
        else if (free_found)
        begin
            victim = free_way;
        end
        else if (repl_mode)
        begin
            victim = random_way;
        end
        else
        begin
            victim = old_way;
        end

        new_valid = valid;
        for (int w = 0; w < WAYS; w++)
        begin
            new_ways[w].tag    = ways[w].tag;
            new_ways[w].target = ways[w].target;
            new_ways[w].age    = aged[w];
        end
        new_ways[victim].target = stored_target;
        new_ways[victim].age    = '0;
        if (!hit_found)
        begin
            new_ways[victim].tag = tag;
            new_valid[victim]    = 1'b1;
        end

        if (!hit_found)
        begin
            result.outcome = OUTCOME_MISS;
        end
        else if (ways[hit_way].target == stored_target)
        begin
            result.outcome = OUTCOME_CORRECT;
        end
        else
        begin
            result.outcome = OUTCOME_MISPREDICT;
        end
        result.lfsr_step = !hit_found && !free_found && repl_mode;
    end

endmodule

FILE: rtl/keyed_branch_target_buffer_core.sv
// ----------------------------------------------------------------------------
// keyed_branch_target_buffer_core: keyed set-associative branch target buffer
// Takes one resolved branch per cycle while in_stall is low and returns one
// outcome beat for each (miss and filled, target mispredicted, target
// correct). A branch accepted at one clock edge is held in the lookup stage,
// fed by the single registered read of the per-way RAMs at accept time, and
// its outcome is loaded into the output register when the stage advances
// after compare and write-back. A branch to the same set as the one just
// ahead of it takes the freshly updated set from a bypass register. Valid bits
// live in flip-flops cleared by reset, so no clearing pass is needed.
// Configuration writes take effect at once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module keyed_branch_target_buffer_core
    import kbtb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ADDR_BITS-1:0] branch_pc,
    input  logic [ADDR_BITS-1:0] branch_target,
    input  logic                 domain_id,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           outcome
);

    // Configuration registers
    domain_keys_t keys0_reg;
    domain_keys_t keys1_reg;
    logic         repl_mode_reg;

    // Lookup stage
    logic             s1_valid_reg, s1_valid_next;
    set_idx_t         s1_set_reg;
    logic [TAG_W-1:0] s1_tag_reg;
    logic [TGT_W-1:0] s1_stored_reg;

    // Bypass of the set written by the previous beat
    logic              byp_use_reg, byp_use_next;
    entry_t [WAYS-1:0] byp_ways_reg;

    logic [WAYS-1:0]   valid_reg [SETS];
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] outcome_reg;

    logic             accept;
    logic             s1_advance;
    set_idx_t         in_set;
    logic [TAG_W-1:0] in_tag;
    logic [TGT_W-1:0] in_stored;

    entry_t [WAYS-1:0] rd_ways;
    entry_t [WAYS-1:0] cur_ways;
    entry_t [WAYS-1:0] new_ways;
    logic   [WAYS-1:0] new_valid;
    set_result_t       result;

    function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

    // Hold the lookup stage while the output register is full and stalled
    assign s1_advance = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall   = s1_valid_reg && out_valid_reg && out_stall;
    assign accept     = in_valid && !in_stall;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys0_reg     <= '0;
            keys1_reg     <= '0;
            repl_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_D0_INDEX_KEY:   keys0_reg.index_key   <= cfg_data[IKEY_W-1:0];
                CFG_D0_INDEX_HASH:  keys0_reg.index_hash  <= cfg_data[CIPHER_W-1:0];
                CFG_D0_CONTENT_KEY: keys0_reg.content_key <= cfg_data[TGT_W-1:0];
                CFG_D1_INDEX_KEY:   keys1_reg.index_key   <= cfg_data[IKEY_W-1:0];
                CFG_D1_INDEX_HASH:  keys1_reg.index_hash  <= cfg_data[CIPHER_W-1:0];
                CFG_D1_CONTENT_KEY: keys1_reg.content_key <= cfg_data[TGT_W-1:0];
                CFG_REPL_MODE:      repl_mode_reg         <= cfg_data[0];
                default:            ;  // drop writes to unused indexes
            endcase
        end
    end

    // ---------------------------------------------------------------- index
    // Scramble straight off the input ports so the RAM read issues at accept
    kbtb_index u_index (
        .branch_pc     (branch_pc),
        .branch_target (branch_target),
        .domain_id     (domain_id),
        .keys0         (keys0_reg),
        .keys1         (keys1_reg),
        .set_idx       (in_set),
        .tag           (in_tag),
        .stored_target (in_stored)
    );

    // ---------------------------------------------------------------- way RAMs
    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        kbtb_way_ram u_ram (
            .clk     (clk),
            .rd_en   (accept),
            .rd_addr (in_set),
            .rd_data (rd_ways[g]),
            .wr_en   (s1_advance),
            .wr_addr (s1_set_reg),
            .wr_data (new_ways[g])
        );
    end

    // Take the bypass copy when the RAM read raced the previous write-back
    assign cur_ways = byp_use_reg ? byp_ways_reg : rd_ways;

    kbtb_set_update u_update (
        .ways          (cur_ways),
        .valid         (valid_reg[s1_set_reg]),
        .tag           (s1_tag_reg),
        .stored_target (s1_stored_reg),
        .repl_mode     (repl_mode_reg),
        .random_way    (lfsr_reg[WAY_BITS-1:0]),
        .new_ways      (new_ways),
        .new_valid     (new_valid),
        .result        (result)
    );

    // ---------------------------------------------------------------- control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        byp_use_next = byp_use_reg;
        if (accept)
        begin
            byp_use_next = s1_advance && (in_set == s1_set_reg);
        end

        // advance the LFSR only on random replacements
        lfsr_next = lfsr_reg;
        if (s1_advance && result.lfsr_step)
        begin
            lfsr_next = lfsr_advance(lfsr_reg);
        end

        // hold a stalled beat, load a new one when the stage advances
        out_valid_next = s1_advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_use_reg   <= 1'b0;
            lfsr_reg      <= LFSR_SEED;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            byp_use_reg   <= byp_use_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                valid_reg[s1_set_reg] <= new_valid;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_set_reg    <= in_set;
            s1_tag_reg    <= in_tag;
            s1_stored_reg <= in_stored;
            byp_ways_reg  <= new_ways;
        end
        if (s1_advance)
        begin
            outcome_reg <= result.outcome;
        end
    end

    assign out_valid = out_valid_reg;
    assign outcome   = outcome_reg;

endmodule
